@@ design/ordered_array_list_engine_macros.svh @@
// ----------------------------------------------------------------------------
// ordered array list engine assertion macros
// concurrent assertion shorthands used by the engine top
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define OALE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OALE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/oale_pkg.sv @@
// ----------------------------------------------------------------------------
// oale_pkg
// shared types, codes and constants of the ordered array list engine
// ----------------------------------------------------------------------------
package oale_pkg;

   localparam int CAPACITY_DEFAULT = 128;
   localparam int WORD_W           = 32;
   localparam int KIND_W           = 4;
   localparam int STATUS_W         = 3;
   localparam int POSITION_W       = 7;
   localparam int COUNT_W          = 8;
   localparam int INDEX_MAX_W      = 12;
   localparam int COUNT_MAX_W      = 13;
   localparam int GROUP_SIZE       = 32;
   localparam int GROUP_IDX_W      = 5;

   localparam logic [GROUP_SIZE-1:0] LANE_MASK [GROUP_IDX_W] = '{
      32'hAAAA_AAAA, 32'hCCCC_CCCC, 32'hF0F0_F0F0, 32'hFF00_FF00, 32'hFFFF_0000
   };

   typedef enum logic [KIND_W-1:0] {
      OP_INS_FRONT  = 4'd0,
      OP_APPEND     = 4'd1,
      OP_INS_BEFORE = 4'd2,
      OP_INS_AFTER  = 4'd3,
      OP_DEL_FRONT  = 4'd4,
      OP_DEL_END    = 4'd5,
      OP_DEL_BEFORE = 4'd6,
      OP_DEL_AFTER  = 4'd7,
      OP_SEARCH     = 4'd8
   } op_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_FULL        = 3'd1,
      ST_EMPTY       = 3'd2,
      ST_NOT_FOUND   = 3'd3,
      ST_NO_NEIGHBOR = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_LOCATE,
      S_APPLY
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type           cmd;
      logic [INDEX_MAX_W-1:0] pos;
      logic [WORD_W-1:0]      word;
      logic [WORD_W-1:0]      key;
      logic [COUNT_MAX_W-1:0] count;
   } cell_ctrl_type;

endpackage

@@ design/oale_req_if.sv @@
// ----------------------------------------------------------------------------
// oale_req_if
// operation request channel: kind, value and reference
// ----------------------------------------------------------------------------
interface oale_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [oale_pkg::KIND_W-1:0]          kind;
   logic signed [oale_pkg::WORD_W-1:0]   value;
   logic signed [oale_pkg::WORD_W-1:0]   reference;

   modport source (output valid, output kind, output value, output reference, input ready);
   modport sink   (input valid, input kind, input value, input reference, output ready);
endinterface

@@ design/oale_rsp_if.sv @@
// ----------------------------------------------------------------------------
// oale_rsp_if
// operation result channel: status, position and count
// ----------------------------------------------------------------------------
interface oale_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [oale_pkg::STATUS_W-1:0]       status;
   logic [oale_pkg::POSITION_W-1:0]     position;
   logic [oale_pkg::COUNT_W-1:0]        count;

   modport source (output valid, output status, output position, output count, input ready);
   modport sink   (input valid, input status, input position, input count, output ready);
endinterface

@@ design/oale_cell.sv @@
// ----------------------------------------------------------------------------
// oale_cell
// one list slot: holds an entry, compares it with the key, and shifts
// toward its left or right neighbor on insert or remove
// ----------------------------------------------------------------------------
module oale_cell (
   input  logic                                   clock,
   input  logic [oale_pkg::COUNT_MAX_W-1:0]       cell_index,
   input  oale_pkg::cell_ctrl_type                ctrl,
   input  logic [oale_pkg::WORD_W-1:0]            left_entry,
   input  logic [oale_pkg::WORD_W-1:0]            right_entry,
   output logic [oale_pkg::WORD_W-1:0]            entry,
   output logic                                   match
);

   logic [oale_pkg::WORD_W-1:0]      entry_ff;
   logic [oale_pkg::WORD_W-1:0]      entry_in;
   logic [oale_pkg::COUNT_MAX_W-1:0] pos_ext;

   assign pos_ext = oale_pkg::COUNT_MAX_W'(ctrl.pos);

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.cmd)
         oale_pkg::CELL_INSERT: begin
            if (cell_index > pos_ext) begin
               entry_in = left_entry;
            end else if (cell_index == pos_ext) begin
               entry_in = ctrl.word;
            end
         end
         oale_pkg::CELL_REMOVE: begin
            if (cell_index >= pos_ext) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (cell_index < ctrl.count) && (entry_ff == ctrl.key);

endmodule

@@ design/oale_locator.sv @@
// ----------------------------------------------------------------------------
// oale_locator
// first-match finder: encodes the first hit of each 32-cell group at start,
// then walks the groups in order, one group a cycle
// ----------------------------------------------------------------------------
module oale_locator #(
   parameter int  CAPACITY   = oale_pkg::CAPACITY_DEFAULT,
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int NUM_GROUPS =
      (CAPACITY + oale_pkg::GROUP_SIZE - 1) / oale_pkg::GROUP_SIZE
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  logic [NUM_GROUPS*oale_pkg::GROUP_SIZE-1:0]     match,
   output logic                                           done,
   output logic                                           found,
   output logic [IDX_W-1:0]                               index
);

   localparam int PTR_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int WIDE_W     = PTR_W + oale_pkg::GROUP_IDX_W;

   logic                               scan_ff;
   logic                               scan_in;
   logic [PTR_W-1:0]                   ptr_ff;
   logic [PTR_W-1:0]                   ptr_in;
   logic [NUM_GROUPS-1:0]              grp_hit_ff;
   logic [NUM_GROUPS-1:0]              grp_hit_in;
   logic [oale_pkg::GROUP_IDX_W-1:0]   grp_idx_ff [NUM_GROUPS];
   logic [oale_pkg::GROUP_IDX_W-1:0]   grp_idx_in [NUM_GROUPS];
   logic [NUM_GROUPS-1:0]              enc_hit;
   logic [oale_pkg::GROUP_IDX_W-1:0]   enc_idx [NUM_GROUPS];
   logic [WIDE_W-1:0]                  index_wide;
   logic                               last_group;

   // per-group lowest set bit and its encoding
   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_enc
      logic [oale_pkg::GROUP_SIZE-1:0] bits;
      logic [oale_pkg::GROUP_SIZE-1:0] lowest;
      assign bits       = match[g*oale_pkg::GROUP_SIZE +: oale_pkg::GROUP_SIZE];
      assign lowest     = bits & (~bits + oale_pkg::GROUP_SIZE'(1));
      assign enc_hit[g] = |bits;
      for (genvar b = 0; b < oale_pkg::GROUP_IDX_W; b++) begin : g_bit
         assign enc_idx[g][b] = |(lowest & oale_pkg::LANE_MASK[b]);
      end
   end

   assign last_group = (ptr_ff == PTR_W'(NUM_GROUPS - 1));
   assign found      = scan_ff && grp_hit_ff[0];
   assign done       = scan_ff && (grp_hit_ff[0] || last_group);
   assign index_wide = {ptr_ff, grp_idx_ff[0]};
   assign index      = IDX_W'(index_wide);

   always_comb begin
      scan_in    = scan_ff;
      ptr_in     = ptr_ff;
      grp_hit_in = grp_hit_ff;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_idx_in[g] = grp_idx_ff[g];
      end
      if (start) begin
         scan_in    = 1'b1;
         ptr_in     = '0;
         grp_hit_in = enc_hit;
         for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_idx_in[g] = enc_idx[g];
         end
      end else if (scan_ff) begin
         scan_in    = !done;
         ptr_in     = ptr_ff + PTR_W'(1);
         grp_hit_in = grp_hit_ff >> 1;
         for (int g = 0; g < NUM_GROUPS - 1; g++) begin
            grp_idx_in[g] = grp_idx_ff[g+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= 1'b0;
      end else begin
         scan_ff <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      grp_hit_ff <= grp_hit_in;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_idx_ff[g] <= grp_idx_in[g];
      end
   end

endmodule

@@ design/ordered_array_list_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// ordered list of signed words kept in a chain of cells, with insert,
// delete and search operations that each return status, position and count
//
//   channel    dir   handshake            payload
//   req_chan   in    valid / ready        kind, value, reference
//   rsp_chan   out   valid / ready        status, position, count
//
// one operation at a time; front/end ops, unused codes, inserts into a full
// list and deletes from an empty list go from transfer to the commit step;
// other reference ops and all searches pass through compare and locate first,
// where the locator walks G = 1 to ceil(CAPACITY/32) groups before commit
// reset clears the state, the count and the result valid; entries need no clearing
// a held result stalls the commit step until the result transfer
// ----------------------------------------------------------------------------
`include "ordered_array_list_engine_macros.svh"

module ordered_array_list_engine #(
   parameter int CAPACITY = oale_pkg::CAPACITY_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   oale_req_if.sink      req_chan,
   oale_rsp_if.source    rsp_chan
);

   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int NUM_GROUPS = (CAPACITY + oale_pkg::GROUP_SIZE - 1) / oale_pkg::GROUP_SIZE;
   localparam int MATCH_W    = NUM_GROUPS * oale_pkg::GROUP_SIZE;

   oale_pkg::state_type                  state_ff;
   oale_pkg::state_type                  state_in;
   logic [oale_pkg::KIND_W-1:0]          kind_ff;
   logic [oale_pkg::WORD_W-1:0]          value_ff;
   logic [oale_pkg::WORD_W-1:0]          reference_ff;
   logic [CNT_W-1:0]                     count_ff;
   logic [CNT_W-1:0]                     count_in;
   logic                                 found_ff;
   logic [IDX_W-1:0]                     match_idx_ff;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [oale_pkg::STATUS_W-1:0]        status_ff;
   logic [oale_pkg::POSITION_W-1:0]      position_ff;
   logic [oale_pkg::COUNT_W-1:0]         count_out_ff;

   logic                                 req_fire;
   logic                                 slot_free;
   logic                                 apply_fire;
   logic                                 full;
   logic                                 empty;
   logic                                 needs_search;
   logic                                 loc_start;
   logic                                 loc_done;
   logic                                 loc_found;
   logic [IDX_W-1:0]                     loc_index;
   logic [CNT_W-1:0]                     m_ext;
   oale_pkg::status_type                 apply_status;
   logic [CNT_W-1:0]                     apply_pos;
   logic [CNT_W-1:0]                     apply_count;
   oale_pkg::cell_cmd_type               apply_cmd;
   oale_pkg::cell_ctrl_type              ctrl;
   logic [31:0]                          pos_wide;
   logic [31:0]                          count_wide;
   logic [oale_pkg::WORD_W-1:0]          entry_w [CAPACITY];
   logic [MATCH_W-1:0]                   match_w;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign apply_fire = (state_ff == oale_pkg::S_APPLY) && slot_free;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign m_ext      = CNT_W'(match_idx_ff);

   always_comb begin
      case (req_chan.kind)
         oale_pkg::OP_INS_BEFORE, oale_pkg::OP_INS_AFTER:   needs_search = !full;
         oale_pkg::OP_DEL_BEFORE, oale_pkg::OP_DEL_AFTER:   needs_search = !empty;
         oale_pkg::OP_SEARCH:                               needs_search = 1'b1;
         default:                                           needs_search = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         oale_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = needs_search ? oale_pkg::S_COMPARE : oale_pkg::S_APPLY;
            end
         end
         oale_pkg::S_COMPARE: begin
            state_in = oale_pkg::S_LOCATE;
         end
         oale_pkg::S_LOCATE: begin
            if (loc_done) begin
               state_in = oale_pkg::S_APPLY;
            end
         end
         oale_pkg::S_APPLY: begin
            if (slot_free) begin
               state_in = oale_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = oale_pkg::S_IDLE;
         end
      endcase
   end

   // operation outcome
   always_comb begin
      apply_status = oale_pkg::ST_OK;
      apply_pos    = '0;
      apply_cmd    = oale_pkg::CELL_HOLD;
      case (kind_ff)
         oale_pkg::OP_INS_FRONT, oale_pkg::OP_APPEND: begin
            if (full) begin
               apply_status = oale_pkg::ST_FULL;
            end else begin
               apply_cmd = oale_pkg::CELL_INSERT;
               apply_pos = (kind_ff == oale_pkg::OP_APPEND) ? count_ff : '0;
            end
         end
         oale_pkg::OP_INS_BEFORE, oale_pkg::OP_INS_AFTER: begin
            if (full) begin
               apply_status = oale_pkg::ST_FULL;
            end else if (!found_ff) begin
               apply_status = oale_pkg::ST_NOT_FOUND;
            end else begin
               apply_cmd = oale_pkg::CELL_INSERT;
               apply_pos = (kind_ff == oale_pkg::OP_INS_AFTER) ? m_ext + CNT_W'(1) : m_ext;
            end
         end
         oale_pkg::OP_DEL_FRONT, oale_pkg::OP_DEL_END: begin
            if (empty) begin
               apply_status = oale_pkg::ST_EMPTY;
            end else begin
               apply_cmd = oale_pkg::CELL_REMOVE;
               apply_pos = (kind_ff == oale_pkg::OP_DEL_END) ? count_ff - CNT_W'(1) : '0;
            end
         end
         oale_pkg::OP_DEL_BEFORE, oale_pkg::OP_DEL_AFTER: begin
            if (empty) begin
               apply_status = oale_pkg::ST_EMPTY;
            end else if (!found_ff) begin
               apply_status = oale_pkg::ST_NOT_FOUND;
            end else if ((kind_ff == oale_pkg::OP_DEL_BEFORE) && (m_ext == '0)) begin
               apply_status = oale_pkg::ST_NO_NEIGHBOR;
            end else if ((kind_ff == oale_pkg::OP_DEL_AFTER) &&
                         (m_ext + CNT_W'(1) >= count_ff)) begin
               apply_status = oale_pkg::ST_NO_NEIGHBOR;
            end else begin
               apply_cmd = oale_pkg::CELL_REMOVE;
               apply_pos = (kind_ff == oale_pkg::OP_DEL_BEFORE) ? m_ext - CNT_W'(1)
                                                               : m_ext + CNT_W'(1);
            end
         end
         oale_pkg::OP_SEARCH: begin
            if (!found_ff) begin
               apply_status = oale_pkg::ST_NOT_FOUND;
            end else begin
               apply_pos = m_ext;
            end
         end
         default: begin
            apply_status = oale_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      case (apply_cmd)
         oale_pkg::CELL_INSERT: apply_count = count_ff + CNT_W'(1);
         oale_pkg::CELL_REMOVE: apply_count = count_ff - CNT_W'(1);
         default:               apply_count = count_ff;
      endcase
   end

   // outputs of the control
   always_comb begin
      req_chan.ready = (state_ff == oale_pkg::S_IDLE);
      loc_start      = (state_ff == oale_pkg::S_COMPARE);
      ctrl.cmd       = apply_fire ? apply_cmd : oale_pkg::CELL_HOLD;
      ctrl.pos       = oale_pkg::INDEX_MAX_W'(apply_pos);
      ctrl.word      = value_ff;
      ctrl.key       = (kind_ff == oale_pkg::OP_SEARCH) ? value_ff : reference_ff;
      ctrl.count     = oale_pkg::COUNT_MAX_W'(count_ff);
      count_in       = apply_fire ? apply_count : count_ff;
      rsp_valid_in   = apply_fire || (rsp_valid_ff && !rsp_chan.ready);
   end

   assign pos_wide   = 32'(apply_pos);
   assign count_wide = 32'(apply_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oale_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff      <= req_chan.kind;
         value_ff     <= req_chan.value;
         reference_ff <= req_chan.reference;
      end
      if (loc_done) begin
         found_ff     <= loc_found;
         match_idx_ff <= loc_index;
      end
      if (apply_fire) begin
         status_ff    <= apply_status;
         position_ff  <= pos_wide[oale_pkg::POSITION_W-1:0];
         count_out_ff <= count_wide[oale_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = status_ff;
   assign rsp_chan.position = position_ff;
   assign rsp_chan.count    = count_out_ff;

   // cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [oale_pkg::WORD_W-1:0] left_w;
      logic [oale_pkg::WORD_W-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = ctrl.word;
      end else begin : g_left
         assign left_w = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = entry_w[i];
      end else begin : g_right
         assign right_w = entry_w[i+1];
      end
      oale_cell u_cell (
         .clock       (clock),
         .cell_index  (oale_pkg::COUNT_MAX_W'(i)),
         .ctrl        (ctrl),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry       (entry_w[i]),
         .match       (match_w[i])
      );
   end

   for (genvar i = CAPACITY; i < MATCH_W; i++) begin : g_pad
      assign match_w[i] = 1'b0;
   end

   oale_locator #(
      .CAPACITY (CAPACITY)
   ) u_locator (
      .clock (clock),
      .reset (reset),
      .start (loc_start),
      .match (match_w),
      .done  (loc_done),
      .found (loc_found),
      .index (loc_index)
   );

   `OALE_ASSERT_IMPLY(count_bound_a, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY),
      "count above capacity")
   `OALE_ASSERT_IMPLY(locate_window_a, clock, reset, loc_done,
      state_ff == oale_pkg::S_LOCATE, "locator done outside locate")
   `OALE_ASSERT_IMPLY(fail_position_a, clock, reset,
      rsp_valid_ff && (status_ff != oale_pkg::ST_OK), position_ff == '0,
      "nonzero position on failure")
   `OALE_ASSERT_NEXT(count_step_a, clock, reset, apply_fire,
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1)) ||
      (count_ff == $past(count_ff) - CNT_W'(1)), "count moved by more than one")
   `OALE_ASSERT_NEXT(busy_after_transfer_a, clock, reset, req_fire,
      state_ff != oale_pkg::S_IDLE, "idle right after request transfer")

endmodule

@@ sim/ordered_array_list_engine_tb.sv @@
// ----------------------------------------------------------------------------
// ordered_array_list_engine_tb
// self-checking bench for the ordered array list engine: a short table of
// directed operations walks the empty, boundary and neighbor cases, then
// fill- and drain-biased random traffic pushes the list to full and back to
// empty under four idle/stall patterns; every result is checked against the
// directed table or an in-bench model of the list
// ----------------------------------------------------------------------------
module ordered_array_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import oale_pkg::*;

   localparam int LIST_CAPACITY  = CAPACITY_DEFAULT;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int FILL_ITEMS     = 300;
   localparam int EMPTY_ITEMS    = 200;
   localparam int DIRECTED_N     = 26;

   localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd9;
   localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

   typedef struct packed {
      status_type            status;
      logic [POSITION_W-1:0] position;
      logic [COUNT_W-1:0]    count;
   } list_result_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] refv;
      bit                typed;
      list_result_type   rsp;
   } directed_row_type;

   // rows with typed = 0 take their result from the list model
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_N] = '{
      '{OP_DEL_FRONT,  32'h0,         32'h0,         1'b1, '{ST_EMPTY,       7'd0, 8'd0}},
      '{OP_DEL_END,    32'h0,         32'h0,         1'b1, '{ST_EMPTY,       7'd0, 8'd0}},
      '{OP_DEL_BEFORE, 32'h0,         32'h0,         1'b1, '{ST_EMPTY,       7'd0, 8'd0}},
      '{OP_DEL_AFTER,  32'h0,         32'h0,         1'b1, '{ST_EMPTY,       7'd0, 8'd0}},
      '{OP_SEARCH,     32'h0,         32'h0,         1'b1, '{ST_NOT_FOUND,   7'd0, 8'd0}},
      '{OP_INS_BEFORE, 32'h1,         32'h0,         1'b1, '{ST_NOT_FOUND,   7'd0, 8'd0}},
      '{OP_INS_AFTER,  32'h1,         32'h0,         1'b1, '{ST_NOT_FOUND,   7'd0, 8'd0}},
      '{OP_INS_FRONT,  32'h8000_0000, 32'h0,         1'b1, '{ST_OK,          7'd0, 8'd1}},
      '{OP_APPEND,     32'h7FFF_FFFF, 32'h0,         1'b1, '{ST_OK,          7'd1, 8'd2}},
      '{OP_APPEND,     32'h0,         32'hFFFF_FFFF, 1'b1, '{ST_OK,          7'd2, 8'd3}},
      '{OP_APPEND,     32'hFFFF_FFFF, 32'h0,         1'b1, '{ST_OK,          7'd3, 8'd4}},
      '{OP_INS_BEFORE, 32'h5,         32'h8000_0000, 1'b1, '{ST_OK,          7'd0, 8'd5}},
      '{OP_INS_AFTER,  32'h6,         32'hFFFF_FFFF, 1'b1, '{ST_OK,          7'd5, 8'd6}},
      '{OP_SEARCH,     32'h0,         32'h0,         1'b1, '{ST_OK,          7'd3, 8'd6}},
      '{OP_DEL_BEFORE, 32'h0,         32'h5,         1'b1, '{ST_NO_NEIGHBOR, 7'd0, 8'd6}},
      '{OP_DEL_AFTER,  32'h0,         32'h6,         1'b1, '{ST_NO_NEIGHBOR, 7'd0, 8'd6}},
      '{OP_DEL_BEFORE, 32'h0,         32'h9,         1'b1, '{ST_NOT_FOUND,   7'd0, 8'd6}},
      '{OP_DEL_AFTER,  32'h0,         32'h0,         1'b1, '{ST_OK,          7'd4, 8'd5}},
      '{OP_DEL_BEFORE, 32'h0,         32'h0,         1'b1, '{ST_OK,          7'd2, 8'd4}},
      '{OP_DEL_END,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK,          7'd3, 8'd3}},
      '{OP_DEL_FRONT,  32'h0,         32'h0,         1'b1, '{ST_OK,          7'd0, 8'd2}},
      '{KIND_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK,         7'd0, 8'd2}},
      '{KIND_UNUSED_HI, 32'h0,        32'h0,         1'b1, '{ST_OK,          7'd0, 8'd2}},
      '{OP_SEARCH,     32'h1,         32'h0,         1'b1, '{ST_NOT_FOUND,   7'd0, 8'd2}},
      '{OP_APPEND,     32'h0,         32'h0,         1'b0, '{ST_OK,          7'd0, 8'd0}},
      '{OP_INS_AFTER,  32'h7,         32'h0,         1'b0, '{ST_OK,          7'd0, 8'd0}}
   };

   logic clock;
   logic reset;

   oale_req_if req_bus ();
   oale_rsp_if rsp_bus ();

   ordered_array_list_engine #(
      .CAPACITY (LIST_CAPACITY)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   logic [WORD_W-1:0] list_word [LIST_CAPACITY];
   int                list_len;
   list_result_type   pending_results [$];

   int send_idle_pct;
   int stall_pct;
   int mismatch_count;
   int ops_sent;
   int results_seen;
   int full_rejects;
   int empty_rejects;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // list model
   // ------------------------------------------------------------------------
   function automatic int find_first(logic [WORD_W-1:0] key);
      for (int i = 0; i < list_len; i++) begin
         if (list_word[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic void insert_word(int at, logic [WORD_W-1:0] word);
      for (int i = list_len; i > at; i--) list_word[i] = list_word[i-1];
      list_word[at] = word;
      list_len++;
   endfunction

   function automatic void remove_word(int at);
      for (int i = at; i + 1 < list_len; i++) list_word[i] = list_word[i+1];
      list_len--;
   endfunction

   function automatic list_result_type apply_list_op(logic [KIND_W-1:0] kind,
                                                     logic [WORD_W-1:0] value,
                                                     logic [WORD_W-1:0] refv);
      list_result_type res;
      int              at;
      int              hit;
      bit              full;
      bit              empty;
      res.status = ST_OK;
      at = 0;
      full = list_len >= LIST_CAPACITY;
      empty = list_len == 0;
      case (kind)
         OP_INS_FRONT, OP_APPEND: begin
            if (full) begin
               res.status = ST_FULL;
            end else begin
               at = (kind == OP_INS_FRONT) ? 0 : list_len;
               insert_word(at, value);
            end
         end
         OP_INS_BEFORE, OP_INS_AFTER: begin
            hit = find_first(refv);
            if (full) begin
               res.status = ST_FULL;
            end else if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               at = (kind == OP_INS_AFTER) ? hit + 1 : hit;
               insert_word(at, value);
            end
         end
         OP_DEL_FRONT, OP_DEL_END: begin
            if (empty) begin
               res.status = ST_EMPTY;
            end else begin
               at = (kind == OP_DEL_FRONT) ? 0 : list_len - 1;
               remove_word(at);
            end
         end
         OP_DEL_BEFORE, OP_DEL_AFTER: begin
            hit = find_first(refv);
            if (empty) begin
               res.status = ST_EMPTY;
            end else if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else if (kind == OP_DEL_BEFORE && hit == 0) begin
               res.status = ST_NO_NEIGHBOR;
            end else if (kind == OP_DEL_AFTER && hit + 1 >= list_len) begin
               res.status = ST_NO_NEIGHBOR;
            end else begin
               at = (kind == OP_DEL_BEFORE) ? hit - 1 : hit + 1;
               remove_word(at);
            end
         end
         OP_SEARCH: begin
            hit = find_first(value);
            if (hit < 0) res.status = ST_NOT_FOUND;
            else at = hit;
         end
         default: begin
         end
      endcase
      res.position = at[POSITION_W-1:0];
      res.count = list_len[COUNT_W-1:0];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(9))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'($urandom_range(7));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_present(int hit_pct);
      if (list_len > 0 && $urandom_range(99) < hit_pct)
         return list_word[$urandom_range(list_len - 1)];
      return random_word();
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind(bit filling);
      int r;
      r = $urandom_range(99);
      if (r < 3) return 4'($urandom_range(15, 9));
      if (r < 10) return OP_SEARCH;
      if (r < (filling ? 88 : 35)) return 4'($urandom_range(3));
      return 4'($urandom_range(7, 4));
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("[%0t] mismatch on %s at result %0d: got %0h, expected %0h",
               $realtime, what, results_seen, got, want);
   endtask

   task automatic issue_op(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] value,
                           logic [WORD_W-1:0] refv, bit typed,
                           list_result_type typed_rsp);
      list_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.value     <= value;
      req_bus.reference <= refv;
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_list_op(kind, value, refv);
      if (predicted.status == ST_FULL) full_rejects++;
      if (predicted.status == ST_EMPTY) empty_rejects++;
      pending_results.push_back(typed ? typed_rsp : predicted);
      ops_sent++;
   endtask

   task automatic random_ops(int n, bit filling);
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] refv;
      for (int i = 0; i < n; i++) begin
         kind = pick_kind(filling);
         value = (kind == OP_SEARCH) ? pick_present(75) : pick_present(30);
         refv = pick_present(85);
         issue_op(kind, value, refv, 1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------------
   // result side: random stall, transfer check
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_bus.status, 0);
         end else begin
            list_result_type want;
            want = pending_results.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.position !== want.position)
               report_mismatch("position", rsp_bus.position, want.position);
            if (rsp_bus.count !== want.count)
               report_mismatch("count", rsp_bus.count, want.count);
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // ------------------------------------------------------------------------
   // watchdog: cycles without any transfer
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.kind      <= '0;
      req_bus.value     <= '0;
      req_bus.reference <= '0;
      list_len       = 0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      mismatch_count = 0;
      ops_sent       = 0;
      results_seen   = 0;
      full_rejects   = 0;
      empty_rejects  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         issue_op(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].refv,
                  DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);

      // no idling, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 60; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 60; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         random_ops(FILL_ITEMS, 1'b1);
         random_ops(EMPTY_ITEMS, 1'b0);
      end
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d operations and %0d results over four idle/stall patterns",
               ops_sent, results_seen);
      $display("list reached full %0d times and empty %0d times; %0d mismatches",
               full_rejects, empty_rejects, mismatch_count);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
